[rtl/sorted_array_set_engine_top_macros.svh]
// Assertion macros for the sorted array set engine.
// Included by the top level; the macros assume ports named clock and reset.
`ifndef SORTED_ARRAY_SET_ENGINE_TOP_MACROS_SVH
`define SORTED_ARRAY_SET_ENGINE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define SASET_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define SASET_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define SASET_ASSERT(label, prop, msg)
`define SASET_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

[rtl/saset_pkg.sv]
// Shared types and constants of the sorted array set engine.
// Used by the element memory and the top level; depends on nothing else.
package saset_pkg;

   localparam int DEFAULT_CAPACITY = 256;
   localparam int VALUE_W          = 32;
   // Each memory word holds the element and its keep mark in the top bit.
   localparam int WORD_W           = VALUE_W + 1;
   localparam int COUNT_OUT_W      = 9;
   localparam int OP_W             = 3;

   localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
   localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
   localparam logic [OP_W-1:0] OP_QUERY     = 3'd2;
   localparam logic [OP_W-1:0] OP_INTERSECT = 3'd3;
   localparam logic [OP_W-1:0] OP_CLEAR     = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [VALUE_W-1:0] value;
      logic                      last;
   } req_type;

   typedef struct packed {
      logic                   found;
      logic [COUNT_OUT_W-1:0] count;
      logic                   rejected_full;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CLR,
      ST_SRCH,
      ST_CMP,
      ST_INS,
      ST_PUT,
      ST_REM,
      ST_CMPCT
   } state_type;

endpackage

[rtl/sorted_array_set_engine_top.sv]
// Channel    Ports                    Handshake
// request    start, busy, req_data    taken when start is high and busy is low
// response   rsp_strobe, rsp_data     valid for one cycle, always taken
//
// Every transaction is a binary search of S steps, S <= log2(CAPACITY) + 1, each
// a registered memory read and a compare, after a dispatch. Insert then shifts
// entries up from the top to the insert position, remove shifts the entries above
// it down, and the final intersect compacts the marked entries; the memory ports
// move one entry per cycle. Pending intersect marks add a clearing pass before any
// other operation. The response strobe is high in the first cycle with busy low.
// Reset is synchronous and needs no clearing pass.
//
// Top level of the sorted array set engine; depends on saset_pkg, saset_ram
// and the assertion macro header.
`include "sorted_array_set_engine_top_macros.svh"

module sorted_array_set_engine_top import saset_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);

   state_type         state_ff, state_in;
   req_type           req_ff, req_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     lo_ff, lo_in;
   logic [CW-1:0]     hi_ff, hi_in;
   logic [CW-1:0]     ptr_ff, ptr_in;
   logic [CW-1:0]     kcnt_ff, kcnt_in;
   logic [AW-1:0]     wa_ff, wa_in;
   logic              found_ff, found_in;
   logic              pend_ff, pend_in;
   logic              marks_ff, marks_in;
   logic              rsp_strobe_ff, rsp_strobe_in;
   rsp_type           rsp_ff, rsp_in;

   logic              wr_en;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic              rd_en;
   logic [AW-1:0]     rd_addr;
   logic [WORD_W-1:0] rd_data;

   logic [CW-1:0]     mid;
   logic              kept;
   logic              fin;
   logic              fin_rej;

   saset_ram #(
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign mid  = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign kept = pend_ff && rd_data[WORD_W-1];

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      count_in      = count_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      ptr_in        = ptr_ff;
      kcnt_in       = kcnt_ff;
      wa_in         = wa_ff;
      found_in      = found_ff;
      pend_in       = pend_ff;
      marks_in      = marks_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;
      rd_en         = 1'b0;
      rd_addr       = '0;
      fin           = 1'b0;
      fin_rej       = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               req_in   = req_data;
               lo_in    = '0;
               hi_in    = count_ff;
               ptr_in   = '0;
               found_in = 1'b0;
               pend_in  = 1'b0;
               if (marks_ff && req_data.op != OP_INTERSECT) begin
                  state_in = ST_CLR;
               end else begin
                  state_in = ST_SRCH;
               end
            end
         end
         ST_CLR: begin
            // Rewrite every live entry with its keep mark cleared.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wa_ff;
               wr_data = {1'b0, rd_data[VALUE_W-1:0]};
            end
            if (ptr_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[AW-1:0];
               wa_in   = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               marks_in = 1'b0;
               state_in = ST_SRCH;
            end
         end
         ST_SRCH: begin
            if (lo_ff < hi_ff) begin
               rd_en    = 1'b1;
               rd_addr  = mid[AW-1:0];
               ptr_in   = mid;
               state_in = ST_CMP;
            end else begin
               // lo_ff now holds the lower bound position of the value.
               case (req_ff.op)
                  OP_INSERT: begin
                     if (found_ff) begin
                        fin = 1'b1;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        fin     = 1'b1;
                        fin_rej = 1'b1;
                     end else begin
                        ptr_in   = count_ff;
                        pend_in  = 1'b0;
                        state_in = ST_INS;
                     end
                  end
                  OP_REMOVE: begin
                     if (found_ff) begin
                        ptr_in   = lo_ff + 1'b1;
                        pend_in  = 1'b0;
                        state_in = ST_REM;
                     end else begin
                        fin = 1'b1;
                     end
                  end
                  OP_INTERSECT: begin
                     if (found_ff) begin
                        wr_en   = 1'b1;
                        wr_addr = lo_ff[AW-1:0];
                        wr_data = {1'b1, req_ff.value};
                     end
                     if (req_ff.last) begin
                        ptr_in   = '0;
                        kcnt_in  = '0;
                        pend_in  = 1'b0;
                        state_in = ST_CMPCT;
                     end else begin
                        marks_in = marks_ff | found_ff;
                        fin      = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                     fin      = 1'b1;
                  end
                  default: begin
                     fin = 1'b1;
                  end
               endcase
            end
         end
         ST_CMP: begin
            if ($signed(rd_data[VALUE_W-1:0]) < req_ff.value) begin
               lo_in = ptr_ff + 1'b1;
            end else begin
               hi_in = ptr_ff;
            end
            if (rd_data[VALUE_W-1:0] == req_ff.value) begin
               found_in = 1'b1;
            end
            state_in = ST_SRCH;
         end
         ST_INS: begin
            // Move entries up by one, from the top down to the insert position.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wa_ff;
               wr_data = {1'b0, rd_data[VALUE_W-1:0]};
            end
            if (ptr_ff > lo_ff) begin
               rd_en   = 1'b1;
               rd_addr = AW'(ptr_ff - 1'b1);
               wa_in   = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff - 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               state_in = ST_PUT;
            end
         end
         ST_PUT: begin
            wr_en    = 1'b1;
            wr_addr  = lo_ff[AW-1:0];
            wr_data  = {1'b0, req_ff.value};
            count_in = count_ff + 1'b1;
            fin      = 1'b1;
         end
         ST_REM: begin
            // Move entries above the removed one down by one.
            if (pend_ff) begin
               wr_en   = 1'b1;
               wr_addr = wa_ff;
               wr_data = {1'b0, rd_data[VALUE_W-1:0]};
            end
            if (ptr_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[AW-1:0];
               wa_in   = AW'(ptr_ff - 1'b1);
               ptr_in  = ptr_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               count_in = count_ff - 1'b1;
               fin      = 1'b1;
            end
         end
         ST_CMPCT: begin
            // Marked entries are packed down in order with their marks cleared.
            if (kept) begin
               wr_en   = 1'b1;
               wr_addr = kcnt_ff[AW-1:0];
               wr_data = {1'b0, rd_data[VALUE_W-1:0]};
            end
            kcnt_in = kcnt_ff + CW'(kept);
            if (ptr_ff < count_ff) begin
               rd_en   = 1'b1;
               rd_addr = ptr_ff[AW-1:0];
               ptr_in  = ptr_ff + 1'b1;
               pend_in = 1'b1;
            end else begin
               pend_in  = 1'b0;
               count_in = kcnt_in;
               marks_in = 1'b0;
               fin      = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (fin) begin
         state_in             = ST_IDLE;
         rsp_strobe_in        = 1'b1;
         rsp_in.found         = found_ff;
         rsp_in.count         = COUNT_OUT_W'(count_in);
         rsp_in.rejected_full = fin_rej;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         pend_ff       <= 1'b0;
         marks_ff      <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         pend_ff       <= pend_in;
         marks_ff      <= marks_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff   <= req_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      ptr_ff   <= ptr_in;
      kcnt_ff  <= kcnt_in;
      wa_ff    <= wa_in;
      found_ff <= found_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `SASET_ASSERT(a_start_goes_busy, (start && !busy) |=> busy, "accepted transaction did not raise busy")
   `SASET_ASSERT(a_rsp_after_busy, rsp_strobe |-> $past(busy), "response without a transaction in flight")
   `SASET_ASSERT(a_reject_when_full, (rsp_strobe && rsp_data.rejected_full) |-> (!rsp_data.found && count_ff == CW'(CAPACITY)), "insert rejected while not full")
   `SASET_ASSERT(a_count_in_range, count_ff <= CW'(CAPACITY), "element count exceeds capacity")

endmodule

[rtl/saset_ram.sv]
// Element memory of the sorted array set engine: one write and one read port,
// read data registered. Depends on saset_pkg for the word width.
module saset_ram import saset_pkg::*; #(
   parameter int DEPTH = DEFAULT_CAPACITY
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WORD_W-1:0]          wr_data,
   input  logic                       rd_en,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WORD_W-1:0]          rd_data
);

   logic [WORD_W-1:0] mem_ff [DEPTH];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
